[rtl/core/stanley_steering_law_unit_defines.svh]
// Assertion macros shared by the core
`ifndef STANLEY_STEERING_LAW_UNIT_DEFINES_SVH
`define STANLEY_STEERING_LAW_UNIT_DEFINES_SVH

// same-cycle implication
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/stl_pkg.sv]
package stl_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int TAB_LEN = 24;
  localparam int SH_W = $clog2(TAB_LEN);

  localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [17:0] STEER_MAX = 18'sd40000;

  localparam logic [1:0] TAG_HEAD = 2'd0;
  localparam logic [1:0] TAG_DIST = 2'd1;
  localparam logic [1:0] TAG_XTRK = 2'd2;

  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_CUR_X = 2'd1;
  localparam logic [1:0] CFG_CUR_Y = 2'd2;

  localparam logic signed [23:0] ATAN_TAB [0:TAB_LEN-1] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451, 24'sd32757,
    24'sd16383, 24'sd8192, 24'sd4096, 24'sd2048, 24'sd1024, 24'sd512,
    24'sd256, 24'sd128, 24'sd64, 24'sd32, 24'sd16, 24'sd8,
    24'sd4, 24'sd2, 24'sd1, 24'sd0, 24'sd0, 24'sd0
  };

  typedef struct packed {
    logic              valid;
    logic [1:0]        tag;
    logic              zero;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [23:0] z;
  } slot_t;

endpackage

[rtl/core/stanley_steering_law_unit.sv]
// channel   | handshake             | payload
// in        | in_valid / in_stall   | op, ref_x, ref_y, ref_heading, speed
// out       | out_valid / out_stall | steer_angle
// cfg       | cfg_valid / cfg_ready | cfg_index, cfg_data
// A pose runs three passes through a row of CORDIC_ITERATIONS CORDIC cells:
// heading and distance enter back to back, the cross-track pass follows after
// the two multiplier states S_MUL1 and S_MUL2; the result is registered in
// S_SUM, after which the unit returns to idle and accepts the next transaction.
// A velocity update or a dropped pose is taken while idle without starting a pass.
// rst is synchronous and clears control state, gain returns to 0.5.
// A waiting result holds the final sum step until out_stall drops.
`include "stanley_steering_law_unit_defines.svh"

module stanley_steering_law_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [23:0] ref_x,
  input  logic signed [23:0] ref_y,
  input  logic signed [14:0] ref_heading,
  input  logic signed [15:0] speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] steer_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INJB  = 3'd1;
  localparam logic [2:0] S_WAITB = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_INJC  = 3'd5;
  localparam logic [2:0] S_WAITC = 3'd6;
  localparam logic [2:0] S_SUM   = 3'd7;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [15:0]        gain;
  logic signed [23:0] cur_x;
  logic signed [23:0] cur_y;
  logic signed [15:0] stored_speed;
  logic               speed_valid;
  logic signed [23:0] hx;
  logic signed [23:0] hy;
  logic signed [14:0] hd;
  logic signed [23:0] z1;
  logic signed [23:0] z2;
  logic [30:0]        xf;
  logic [61:0]        prod;
  logic [41:0]        num;

  logic               accept;
  logic               start;
  logic signed [24:0] dxs;
  logic signed [24:0] dys;
  logic [24:0]        dxa;
  logic [24:0]        dya;
  logic signed [63:0] sx;
  logic signed [63:0] sy;
  logic               sv;
  logic [1:0]         stag;
  stl_pkg::slot_t     ch_in;
  stl_pkg::slot_t     ch_out;
  logic signed [23:0] zq;
  logic [62:0]        prod_r;
  logic [25:0]        span;
  logic signed [25:0] sum;
  logic signed [17:0] res;
  logic signed [16:0] res_sat;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign start     = accept && op && speed_valid;
  assign out_free  = !out_valid || !out_stall;

  assign dxs = 25'(hx) - 25'(cur_x);
  assign dys = 25'(hy) - 25'(cur_y);
  assign dxa = dxs[24] ? 25'(-dxs) : 25'(dxs);
  assign dya = dys[24] ? 25'(-dys) : 25'(dys);

  always_comb begin
    sv   = 1'b0;
    stag = stl_pkg::TAG_HEAD;
    sx   = 64'sd0;
    sy   = 64'sd0;
    priority if (start) begin
      sv = 1'b1;
      sx = 64'(ref_x) <<< 24;
      sy = 64'(ref_y) <<< 24;
    end else if (state == S_INJB) begin
      sv   = 1'b1;
      stag = stl_pkg::TAG_DIST;
      sx   = $signed({35'd0, dxa, 4'd0});
      sy   = $signed({35'd0, dya, 4'd0});
    end else if (state == S_INJC) begin
      sv   = 1'b1;
      stag = stl_pkg::TAG_XTRK;
      sx   = 64'(stored_speed) <<< 32;
      sy   = $signed({6'd0, num, 16'd0});
    end
    ch_in.valid = sv;
    ch_in.tag   = stag;
    ch_in.zero  = (sx == 64'sd0) && (sy == 64'sd0);
    ch_in.x     = sx;
    ch_in.y     = sy;
    ch_in.z     = 24'sd0;
    if (sx < 0) begin
      if (sy >= 0) begin
        ch_in.x = sy;
        ch_in.y = -sx;
        ch_in.z = stl_pkg::HALF_PI_Q20;
      end else begin
        ch_in.x = -sy;
        ch_in.y = sx;
        ch_in.z = -stl_pkg::HALF_PI_Q20;
      end
    end
  end

  stl_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .din  (ch_in),
    .dout (ch_out)
  );

  assign zq = ch_out.zero ? 24'sd0 : ch_out.z;

  assign prod_r = 63'(prod) + (63'd1 <<< 33);
  assign span   = prod_r[59:34];

  assign sum = 26'(z1) + 26'(z2) - (26'(hd) <<< 8) + 26'sd128;
  assign res = sum[25:8];
  always_comb begin
    priority if (res > stl_pkg::STEER_MAX) begin
      res_sat = 17'(stl_pkg::STEER_MAX);
    end else if (res < -stl_pkg::STEER_MAX) begin
      res_sat = 17'(-stl_pkg::STEER_MAX);
    end else begin
      res_sat = res[16:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_INJB;
      S_INJB:  state_next = S_WAITB;
      S_WAITB: if (ch_out.valid && ch_out.tag == stl_pkg::TAG_DIST) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_INJC;
      S_INJC:  state_next = S_WAITC;
      S_WAITC: if (ch_out.valid && ch_out.tag == stl_pkg::TAG_XTRK) state_next = S_SUM;
      S_SUM:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      gain         <= 16'd2048;
      cur_x        <= 24'sd0;
      cur_y        <= 24'sd0;
      stored_speed <= 16'sd0;
      speed_valid  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          stl_pkg::CFG_GAIN:  gain  <= cfg_data[15:0];
          stl_pkg::CFG_CUR_X: cur_x <= $signed(cfg_data);
          stl_pkg::CFG_CUR_Y: cur_y <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (accept && !op) begin
        stored_speed <= speed;
        speed_valid  <= 1'b1;
      end
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hx <= ref_x;
      hy <= ref_y;
      hd <= ref_heading;
    end
    if (ch_out.valid && ch_out.tag == stl_pkg::TAG_HEAD) z1 <= zq;
    if (ch_out.valid && ch_out.tag == stl_pkg::TAG_DIST) begin
      xf <= ch_out.zero ? 31'd0 : ch_out.x[30:0];
    end
    if (ch_out.valid && ch_out.tag == stl_pkg::TAG_XTRK) z2 <= zq;
    if (state == S_MUL1) prod <= 62'(xf) * 62'(stl_pkg::INV_GAIN_Q30);
    if (state == S_MUL2) num <= 42'(gain) * 42'(span);
    if (state == S_SUM && out_free) steer_angle <= res_sat;
  end

  `STL_ASSERT_NOW(a_xtrk_in_wait, ch_out.valid && ch_out.tag == stl_pkg::TAG_XTRK, state == S_WAITC, "cross-track pass out of sequence")
  `STL_ASSERT_NEXT(a_sum_drives_out, state == S_SUM && out_free, out_valid, "result not presented")
  `STL_ASSERT_NOW(a_steer_range, out_valid, steer_angle <= 17'sd40000 && steer_angle >= -17'sd40000, "steer out of range")

endmodule

[rtl/core/stl_cell.sv]
module stl_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [stl_pkg::SH_W-1:0]   shamt,
  input  logic signed [23:0]         angle,
  input  stl_pkg::slot_t             din,
  output stl_pkg::slot_t             dout
);

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  stl_pkg::slot_t     nxt;

  always_comb begin
    dx = din.y >>> shamt;
    dy = din.x >>> shamt;
    nxt = din;
    if (din.y >= 0) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + angle;
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.tag  <= nxt.tag;
    dout.zero <= nxt.zero;
    dout.x    <= nxt.x;
    dout.y    <= nxt.y;
    dout.z    <= nxt.z;
  end

endmodule

[rtl/core/stl_chain.sv]
module stl_chain (
  input  logic           clk,
  input  logic           rst,
  input  stl_pkg::slot_t din,
  output stl_pkg::slot_t dout
);

  stl_pkg::slot_t stage [0:stl_pkg::CORDIC_ITERATIONS];

  assign stage[0] = din;

  for (genvar i = 0; i < stl_pkg::CORDIC_ITERATIONS; i++) begin : g_cell
    stl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shamt (stl_pkg::SH_W'(i)),
      .angle (stl_pkg::ATAN_TAB[i]),
      .din   (stage[i]),
      .dout  (stage[i+1])
    );
  end

  assign dout = stage[stl_pkg::CORDIC_ITERATIONS];

endmodule
